// File: hdl/rpp_pkg.sv
// Shared constants and the arctangent table for the point rotation block.
// No dependencies; used by rpp_cell, rpp_post and the top level.
package rpp_pkg;

	localparam int ANGLE_W   = 16;  // input binary angle
	localparam int ATAN_LEN  = 24;  // entries in the arctangent table
	localparam int XY_W      = 34;  // CORDIC vector, Q1.30 plus headroom
	localparam int Z_W       = 34;  // residual angle, 2^32 = 2*pi
	localparam int Z_SHIFT   = 16;  // input angle to CORDIC angle units
	localparam int TRIG_W    = 28;  // cos/sin after rounding to Q.24
	localparam int TRIG_SH   = 6;   // Q1.30 -> Q.24
	localparam int TRIG_RND  = 32;
	localparam int OUT_SH    = 24;  // product scale back to Q.4

	localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

	// atan(2^-i), truncated, in units where 2^32 is a full turn
	function automatic logic [31:0] atan_lut(input int idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/rpp_cell.sv
// One CORDIC micro-rotation cell with its own pipeline register and handshake.
// Depends on rpp_pkg; side data (offsets, pivot, flip) rides along untouched.
module rpp_cell
	import rpp_pkg::*;
#(
	parameter int STEP   = 0,
	parameter int SIDE_W = 67
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [XY_W-1:0]  x_in,
	input  logic signed [XY_W-1:0]  y_in,
	input  logic signed [Z_W-1:0]   z_in,
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [XY_W-1:0]  x_out,
	output logic signed [XY_W-1:0]  y_out,
	output logic signed [Z_W-1:0]   z_out,
	output logic [SIDE_W-1:0]       side_out
);

	localparam logic signed [Z_W-1:0] ATAN_STEP = signed'(Z_W'(atan_lut(STEP)));

	logic                   valid_q;
	logic signed [XY_W-1:0] x_q, y_q, x_sh, y_sh, x_nx, y_nx;
	logic signed [Z_W-1:0]  z_q, z_nx;
	logic [SIDE_W-1:0]      side_q;
	logic                   load;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	assign x_sh = x_in >>> STEP;
	assign y_sh = y_in >>> STEP;

	always_comb begin
		if (!z_in[Z_W-1]) begin
			x_nx = x_in - y_sh;
			y_nx = y_in + x_sh;
			z_nx = z_in - ATAN_STEP;
		end else begin
			x_nx = x_in + y_sh;
			y_nx = y_in - x_sh;
			z_nx = z_in + ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			z_q    <= z_nx;
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;
	assign side_out  = side_q;

endmodule

// File: hdl/rpp_post.sv
// Back end: rounds cos/sin, multiplies by the offsets, rounds, adds the pivot
// and saturates. Four elastic stages; the last is the output register. Uses rpp_pkg.
module rpp_post
	import rpp_pkg::*;
#(
	parameter int CW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	input  logic [4*CW+2:0]        side_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CW-1:0]          rotated_x,
	output logic [CW-1:0]          rotated_y,
	output logic                   saturated
);

	localparam int DW = CW + 1;
	localparam int PW = DW + TRIG_W;
	localparam int SW = PW + 1;
	localparam int RW = SW - OUT_SH + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (OUT_SH - 1);
	localparam logic signed [RW-1:0] MAXV = RW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [DW-1:0]     dx_in, dy_in;
	logic signed [CW-1:0]     pvx_in, pvy_in;
	logic                     flip_in;
	logic signed [XY_W-1:0]   xr, yr, xr_sh, yr_sh;
	logic signed [TRIG_W-1:0] c_rnd, s_rnd;

	logic signed [TRIG_W-1:0] c_s1, s_s1;
	logic signed [DW-1:0]     dx_s1, dy_s1;
	logic signed [CW-1:0]     pvx_s1, pvy_s1, pvx_s2, pvy_s2, pvx_s3, pvy_s3;
	logic signed [PW-1:0]     xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [SW-1:0]     rx_s3, ry_s3;
	logic signed [RW-1:0]     rx_w, ry_w, rx_c, ry_c;
	logic                     sat_x, sat_y;
	logic [CW-1:0]            rx_s4, ry_s4;
	logic                     sat_s4;

	assign rdy4     = !v4_q || out_ready;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	assign dx_in   = signed'(side_in[DW-1:0]);
	assign dy_in   = signed'(side_in[2*DW-1:DW]);
	assign pvx_in  = signed'(side_in[2*DW+CW-1:2*DW]);
	assign pvy_in  = signed'(side_in[2*DW+2*CW-1:2*DW+CW]);
	assign flip_in = side_in[4*CW+2];

	// Q1.30 -> Q.24, round half up
	assign xr    = x_in + XY_W'(TRIG_RND);
	assign yr    = y_in + XY_W'(TRIG_RND);
	assign xr_sh = xr >>> TRIG_SH;
	assign yr_sh = yr >>> TRIG_SH;
	assign c_rnd = xr_sh[TRIG_W-1:0];
	assign s_rnd = yr_sh[TRIG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			// wide angles ran at angle + pi: negate
			c_s1   <= flip_in ? -c_rnd : c_rnd;
			s_s1   <= flip_in ? -s_rnd : s_rnd;
			dx_s1  <= dx_in;
			dy_s1  <= dy_in;
			pvx_s1 <= pvx_in;
			pvy_s1 <= pvy_in;
		end
		if (rdy2 && v1_q) begin
			xc_s2  <= PW'(dx_s1) * PW'(c_s1);
			ys_s2  <= PW'(dy_s1) * PW'(s_s1);
			xs_s2  <= PW'(dx_s1) * PW'(s_s1);
			yc_s2  <= PW'(dy_s1) * PW'(c_s1);
			pvx_s2 <= pvx_s1;
			pvy_s2 <= pvy_s1;
		end
		if (rdy3 && v2_q) begin
			rx_s3  <= SW'(xc_s2) - SW'(ys_s2) + HALF;
			ry_s3  <= SW'(xs_s2) + SW'(yc_s2) + HALF;
			pvx_s3 <= pvx_s2;
			pvy_s3 <= pvy_s2;
		end
		if (rdy4 && v3_q) begin
			rx_s4  <= rx_c[CW-1:0];
			ry_s4  <= ry_c[CW-1:0];
			sat_s4 <= sat_x || sat_y;
		end
	end

	assign rx_w = RW'(rx_s3 >>> OUT_SH) + RW'(pvx_s3);
	assign ry_w = RW'(ry_s3 >>> OUT_SH) + RW'(pvy_s3);

	always_comb begin
		sat_x = 1'b1;
		sat_y = 1'b1;
		if (rx_w > MAXV)      rx_c = MAXV;
		else if (rx_w < MINV) rx_c = MINV;
		else begin
			rx_c  = rx_w;
			sat_x = 1'b0;
		end
		if (ry_w > MAXV)      ry_c = MAXV;
		else if (ry_w < MINV) ry_c = MINV;
		else begin
			ry_c  = ry_w;
			sat_y = 1'b0;
		end
	end

	assign out_valid = v4_q;
	assign rotated_x = rx_s4;
	assign rotated_y = ry_s4;
	assign saturated = sat_s4;

endmodule

// File: hdl/rotate_point_about_pivot_top.sv
// Rotate a point about a pivot: front-end stage, chain of CORDIC cells, back end.
// Depends on rpp_pkg, rpp_cell and rpp_post.
//
// Usage:
//   Input channel (in_valid/in_ready) carries pivot_x/y, point_x/y (signed
//   Q11.4) and turn_angle (binary angle, 32768 = pi). Output channel
//   (out_valid/out_ready) returns rotated_x/y, saturated to the coordinate
//   range, and saturated, set when either coordinate was clipped.
//   Exactly one result per transfer in, in order.
//   Pipeline: one front-end stage, one cell per micro-rotation (capped at 24),
//   four back-end stages.
//   Throughput: one item per clock while out_ready is high; every stage is a
//   register with its own valid bit, so the whole chain advances while out_ready is high.
//   Stall: when out_ready is low the result holds in the output register;
//   stages behind it keep filling bubbles and in_ready falls only once
//   every stage holds an item. The block keeps no state between items.
//   Reset: arst_n clears all valid bits; nothing else is initialized.
module rotate_point_about_pivot_top
	import rpp_pkg::*;
#(
	parameter int ITERATIONS  = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] pivot_x,
	input  logic [COORD_WIDTH-1:0] pivot_y,
	input  logic [COORD_WIDTH-1:0] point_x,
	input  logic [COORD_WIDTH-1:0] point_y,
	input  logic [ANGLE_W-1:0]     turn_angle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_WIDTH-1:0] rotated_x,
	output logic [COORD_WIDTH-1:0] rotated_y,
	output logic                   saturated
);

	localparam int CW     = COORD_WIDTH;
	localparam int NSTEP  = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;
	localparam int SIDE_W = 4 * CW + 3;

	logic                   v_s0;
	logic signed [XY_W-1:0] x_c [0:NSTEP];
	logic signed [XY_W-1:0] y_c [0:NSTEP];
	logic signed [Z_W-1:0]  z_c [0:NSTEP];
	logic [SIDE_W-1:0]      sd_c [0:NSTEP];
	logic                   vld_c [0:NSTEP];
	logic                   rdy_c [0:NSTEP];

	logic                   flip;
	logic [ANGLE_W-1:0]     ang_fold;
	logic signed [CW:0]     dx, dy;
	logic signed [Z_W-1:0]  z_s0;
	logic [SIDE_W-1:0]      sd_s0;

	// quarter turn or more: run at angle + pi, which is a flip of the sign bit
	assign flip     = turn_angle[ANGLE_W-1] ^ turn_angle[ANGLE_W-2];
	assign ang_fold = flip ? {~turn_angle[ANGLE_W-1], turn_angle[ANGLE_W-2:0]} : turn_angle;
	assign dx = (CW+1)'(signed'(point_x)) - (CW+1)'(signed'(pivot_x));
	assign dy = (CW+1)'(signed'(point_y)) - (CW+1)'(signed'(pivot_y));

	assign in_ready = !v_s0 || rdy_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (in_ready) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			z_s0  <= Z_W'(signed'(ang_fold)) <<< Z_SHIFT;
			sd_s0 <= {flip, pivot_y, pivot_x, dy, dx};
		end
	end

	assign vld_c[0] = v_s0;
	assign x_c[0]   = GAIN_Q30;
	assign y_c[0]   = '0;
	assign z_c[0]   = z_s0;
	assign sd_c[0]  = sd_s0;

	for (genvar i = 0; i < NSTEP; i++) begin : g_cell
		rpp_cell #(
			.STEP   (i),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[i]),
			.in_ready  (rdy_c[i]),
			.x_in      (x_c[i]),
			.y_in      (y_c[i]),
			.z_in      (z_c[i]),
			.side_in   (sd_c[i]),
			.out_valid (vld_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.x_out     (x_c[i+1]),
			.y_out     (y_c[i+1]),
			.z_out     (z_c[i+1]),
			.side_out  (sd_c[i+1])
		);
	end

	rpp_post #(
		.CW (CW)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_c[NSTEP]),
		.in_ready  (rdy_c[NSTEP]),
		.x_in      (x_c[NSTEP]),
		.y_in      (y_c[NSTEP]),
		.side_in   (sd_c[NSTEP]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.saturated (saturated)
	);

endmodule

// File: hdl/rpp_checker.sv
// Port-level checks for rotate_point_about_pivot_top, attached by bind.
// No package dependency; watches the top level's ports only.
module rpp_checker #(
	parameter int CW = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [CW-1:0] rotated_x,
	input logic [CW-1:0] rotated_y,
	input logic          saturated
);

	localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(rotated_x) && $stable(rotated_y)
			&& $stable(saturated))
		else $error("stalled result changed");

	// a draining output means the whole chain can take a transfer
	a_full_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// a clip flag implies a coordinate sits at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> rotated_x == MAXV || rotated_x == MINV
			|| rotated_y == MAXV || rotated_y == MINV)
		else $error("saturated flag without clipped coordinate");

endmodule

bind rotate_point_about_pivot_top rpp_checker #(.CW(COORD_WIDTH)) u_rpp_checker (.*);

// File: test/rotate_point_about_pivot_top_test.sv
// Self-checking bench for rotate_point_about_pivot_top: directed angle and coordinate
// corners, random points with both sides idling, then without. Needs rpp_pkg and the RTL.
`timescale 1ns / 100ps

module rotate_point_about_pivot_top_test
	import rpp_pkg::*;
();

	localparam int ITERATIONS = 16;
	localparam int COORD_W    = 16;
	localparam int LATENCY    = ITERATIONS + 5;
	localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [ANGLE_W-1:0] QUARTER = 16'sd16384;
	localparam logic [ANGLE_W-1:0] HALF    = 16'h8000;

	// atan(2^-i) with a full turn at 2^32
	localparam longint ARCTAN [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
		64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
	};

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               clipped;
	} rotated_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [COORD_W-1:0] pivot_x;
	logic [COORD_W-1:0] pivot_y;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic [ANGLE_W-1:0] turn_angle;
	logic               out_valid;
	logic               out_ready;
	logic [COORD_W-1:0] rotated_x;
	logic [COORD_W-1:0] rotated_y;
	logic               saturated;

	rotated_t pending_points[$];
	bit       sender_idle;
	bit       sink_idle;
	int       points_sent;
	int       wide_turns;
	int       points_checked;
	int       clipped_seen;
	int       mismatch_count;

	rotate_point_about_pivot_top #(
		.ITERATIONS (ITERATIONS),
		.COORD_WIDTH(COORD_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pivot_x   (pivot_x),
		.pivot_y   (pivot_y),
		.point_x   (point_x),
		.point_y   (point_y),
		.turn_angle(turn_angle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cos and sin in Q.24; angles of a quarter turn or more run half a turn off, then flip
	function automatic void cordic_cos_sin(input logic [ANGLE_W-1:0] angle,
			output longint cos24, output longint sin24);
		longint a;
		longint x;
		longint y;
		longint z;
		longint nx;
		bit     flip;
		a = longint'($signed(angle));
		flip = (a >= 16384 || a < -16384);
		if (flip) begin
			a = (a >= 0) ? a - 32768 : a + 32768;
		end
		z = a * 65536;
		x = 652032874;
		y = 0;
		for (int i = 0; i < ITERATIONS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ARCTAN[i];
			end
			x = nx;
		end
		cos24 = (x + 32) >>> 6;
		sin24 = (y + 32) >>> 6;
		if (flip) begin
			cos24 = -cos24;
			sin24 = -sin24;
		end
	endfunction

	function automatic longint clip_coord(input longint v, inout bit clipped);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_W - 1)) - 1;
		lo = -(longint'(1) <<< (COORD_W - 1));
		if (v > hi) begin
			clipped = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clipped = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic rotated_t predict_rotation(input logic [COORD_W-1:0] pvx,
			input logic [COORD_W-1:0] pvy, input logic [COORD_W-1:0] ptx,
			input logic [COORD_W-1:0] pty, input logic [ANGLE_W-1:0] angle);
		longint   c;
		longint   s;
		longint   dx;
		longint   dy;
		longint   rx;
		longint   ry;
		bit       clipped;
		rotated_t r;
		cordic_cos_sin(angle, c, s);
		clipped = 1'b0;
		dx = longint'($signed(ptx)) - longint'($signed(pvx));
		dy = longint'($signed(pty)) - longint'($signed(pvy));
		rx = (dx * c - dy * s + (longint'(1) <<< 23)) >>> 24;
		ry = (dx * s + dy * c + (longint'(1) <<< 23)) >>> 24;
		rx = clip_coord(rx + longint'($signed(pvx)), clipped);
		ry = clip_coord(ry + longint'($signed(pvy)), clipped);
		r.x = rx[COORD_W-1:0];
		r.y = ry[COORD_W-1:0];
		r.clipped = clipped;
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_point(input logic [COORD_W-1:0] pvx, input logic [COORD_W-1:0] pvy,
			input logic [COORD_W-1:0] ptx, input logic [COORD_W-1:0] pty,
			input logic [ANGLE_W-1:0] angle);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		pivot_x    <= pvx;
		pivot_y    <= pvy;
		point_x    <= ptx;
		point_y    <= pty;
		turn_angle <= angle;
		do @(posedge clk); while (!in_ready);
		pending_points.push_back(predict_rotation(pvx, pvy, ptx, pty, angle));
		points_sent++;
		if ($signed(angle) >= 16384 || $signed(angle) < -16384) begin
			wide_turns++;
		end
		@(negedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] near);
		case ($urandom_range(0, 3))
			0: return COORD_W'(near + $urandom_range(0, 511) - 256);
			1: return $urandom_range(0, 1) ? COORD_W'(C_MAX - $urandom_range(0, 63))
					: COORD_W'(C_MIN + $urandom_range(0, 63));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return ANGLE_W'(QUARTER + $urandom_range(0, 7) - 4);
			1: return ANGLE_W'(-QUARTER + $urandom_range(0, 7) - 4);
			2: return ANGLE_W'(HALF + $urandom_range(0, 7) - 4);
			3: return ANGLE_W'($urandom_range(0, 15) - 8);
			default: return ANGLE_W'($urandom);
		endcase
	endfunction

	task automatic test_angle_corners();
		logic [ANGLE_W-1:0] angles[10];
		angles = '{16'd0, 16'd1, 16'hFFFF, 16'd8192, 16'd16383, QUARTER, -QUARTER,
			-QUARTER - 16'd1, 16'h7FFF, HALF};
		foreach (angles[i]) begin
			send_point(16'sd160, -16'sd48, 16'sd1760, 16'sd400, angles[i]);
		end
	endtask

	task automatic test_coordinate_corners();
		send_point(16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'd12345);
		send_point(C_MIN, C_MIN, C_MAX, C_MAX, 16'h7FFF);
		send_point(C_MAX, C_MAX, C_MIN, C_MIN, 16'd0);
		send_point(C_MAX, C_MIN, C_MIN, C_MAX, QUARTER);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, HALF);
		send_point(C_MIN, C_MIN, C_MIN, C_MIN, -QUARTER);
		send_point(16'd0, 16'd0, C_MAX, 16'd0, 16'd8192);
		send_point(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd3);
	endtask

	task automatic test_random_points(input int count);
		logic [COORD_W-1:0] pvx;
		logic [COORD_W-1:0] pvy;
		repeat (count) begin
			pvx = COORD_W'($urandom);
			pvy = COORD_W'($urandom);
			send_point(pvx, pvy, pick_coord(pvx), pick_coord(pvy), pick_angle());
		end
	endtask

	task automatic test_streaming(input int count);
		sender_idle = 1'b0;
		sink_idle = 1'b0;
		test_random_points(count);
	endtask

	// sink side: random stall bursts between ready stretches while sink_idle is set
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_idle && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		rotated_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: result with none pending: x=%h y=%h sat=%b",
						$realtime, rotated_x, rotated_y, saturated);
				end
			end else begin
				want = pending_points.pop_front();
				points_checked++;
				if (saturated) begin
					clipped_seen++;
				end
				if (rotated_x !== want.x || rotated_y !== want.y ||
						saturated !== want.clipped) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: result %0d: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
							$realtime, points_checked, want.x, want.y, want.clipped,
							rotated_x, rotated_y, saturated);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results pending", pending_points.size());
		$display("rotate_point_about_pivot_top_test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pivot_x = '0;
		pivot_y = '0;
		point_x = '0;
		point_y = '0;
		turn_angle = '0;
		sender_idle = 1'b1;
		sink_idle = 1'b1;
		points_sent = 0;
		wide_turns = 0;
		points_checked = 0;
		clipped_seen = 0;
		mismatch_count = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_angle_corners();
		test_coordinate_corners();
		test_random_points(1400);
		test_streaming(300);
		in_valid <= 1'b0;

		while (pending_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("%0d points sent (%0d with turns of a quarter or more), %0d results checked",
			points_sent, wide_turns, points_checked);
		$display("%0d results clipped, %0d mismatches", clipped_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("rotate_point_about_pivot_top_test passed");
		end else begin
			$display("rotate_point_about_pivot_top_test failed");
		end
		$finish;
	end

endmodule
